[rtl/core/npcs_pkg.sv]
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types, codes and constants of the nearest palette color search
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int NPCS_PALETTE_ENTRIES = 256;
  localparam int NPCS_COMP_W          = 16;
  localparam int NPCS_SQ_W            = 2 * NPCS_COMP_W;
  localparam int NPCS_DIST_W          = NPCS_SQ_W + 2;
  localparam int NPCS_LIMIT_W         = 9;
  localparam int NPCS_PIXEL_W         = 8;
  localparam int NPCS_ENTRY_IDX_W     = 8;
  localparam int NPCS_CFG_IDX_W       = 2;
  localparam int NPCS_CFG_DATA_W      = 9;
  localparam int NPCS_PIPE_LAT        = 3;

  localparam logic [NPCS_LIMIT_W-1:0] NPCS_LIMIT_RST = NPCS_LIMIT_W'(256);
  localparam logic [NPCS_PIXEL_W-1:0] NPCS_BLACK_RST = '0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [NPCS_CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = NPCS_CFG_IDX_W'(0);
  localparam logic [NPCS_CFG_IDX_W-1:0] CFG_BLACK_PIXEL    = NPCS_CFG_IDX_W'(1);

  typedef struct packed {
    logic [NPCS_COMP_W-1:0] red;
    logic [NPCS_COMP_W-1:0] green;
    logic [NPCS_COMP_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic   eligible;
    color_t color;
  } cell_t;

  typedef struct packed {
    logic live;
    logic init;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic [NPCS_COMP_W-1:0] abs_diff(
    input logic [NPCS_COMP_W-1:0] a,
    input logic [NPCS_COMP_W-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

[rtl/core/nearest_palette_color_search_top.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// palette store and nearest color search over a rotating ring of entry cells
// ----------------------------------------------------------------------------
// A write request loads one palette entry. A query request first issues the
// distance to black, then the ring of entry cells makes one full turn past the
// single distance unit at its head (one entry a cycle), then the three-stage
// distance pipeline drains and the result goes to the output register. One
// request is worked on at a time; the result may wait in the output register
// while the next request is accepted. Reset clears every eligible bit at once,
// so no clearing pass is needed.
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = NPCS_PALETTE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [NPCS_ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [NPCS_COMP_W-1:0]      in_red,
  input  logic [NPCS_COMP_W-1:0]      in_green,
  input  logic [NPCS_COMP_W-1:0]      in_blue,
  input  logic                        in_eligible,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [NPCS_PIXEL_W-1:0]     out_best_pixel,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [NPCS_CFG_IDX_W-1:0]   cfg_index,
  input  logic [NPCS_CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W      = $clog2(PALETTE_ENTRIES);
  localparam int STEP_W     = $clog2(PALETTE_ENTRIES + 1);
  localparam int CMP_W      = (IDX_W > NPCS_LIMIT_W) ? IDX_W : NPCS_LIMIT_W;
  localparam int WR_CMP_W   = (IDX_W > NPCS_ENTRY_IDX_W) ? IDX_W : NPCS_ENTRY_IDX_W;
  localparam int DRAIN_W    = $clog2(NPCS_PIPE_LAT);
  localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(PALETTE_ENTRIES);
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(NPCS_PIPE_LAT - 1);

  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DRAIN_W-1:0]      drain_r, drain_nxt;
  logic [NPCS_LIMIT_W-1:0] entries_in_use_r;
  logic [NPCS_PIXEL_W-1:0] black_pixel_r;
  color_t                  query_r;
  logic [NPCS_DIST_W-1:0]  best_r;
  logic [NPCS_PIXEL_W-1:0] pixel_r;
  logic                    out_valid_r;
  logic [NPCS_PIXEL_W-1:0] out_pixel_r;

  logic                    in_acc;
  logic                    in_stall_c;
  logic                    issue_init;
  logic                    shift_ring;
  logic                    load_out;
  color_t                  wr_color;
  cell_t                   cells_q [PALETTE_ENTRIES];
  cell_t                   head;
  logic [IDX_W-1:0]        entry_idx;
  ctl_t                    issue_ctl;
  color_t                  issue_color;
  ctl_t                    d_ctl;
  logic [IDX_W-1:0]        d_idx;
  logic [NPCS_DIST_W-1:0]  d_dist;

  assign in_acc   = in_valid && !in_stall_c;
  assign wr_color = '{red: in_red, green: in_green, blue: in_blue};

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= NPCS_LIMIT_RST;
      black_pixel_r    <= NPCS_BLACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ENTRIES_IN_USE) begin
        entries_in_use_r <= cfg_data[NPCS_LIMIT_W-1:0];
      end else if (cfg_index == CFG_BLACK_PIXEL) begin
        black_pixel_r <= cfg_data[NPCS_PIXEL_W-1:0];
      end
    end
  end

  // ring of entry cells, head at cell zero
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    logic wr_hit;
    assign wr_hit = in_acc && (in_command == CMD_WRITE) &&
                    (WR_CMP_W'(in_entry_index) == WR_CMP_W'(k));
    npcs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift       (shift_ring),
      .wr_en       (wr_hit),
      .wr_color    (wr_color),
      .wr_eligible (in_eligible),
      .nb_in       (cells_q[(k + 1) % PALETTE_ENTRIES]),
      .q           (cells_q[k])
    );
  end

  assign head = cells_q[0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    drain_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == CMD_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall_c = 1'b1;
    issue_init = 1'b0;
    shift_ring = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall_c = 1'b0;
      end
      ST_SCAN: begin
        issue_init = (step_r == '0);
        shift_ring = (step_r != '0);
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        load_out = !out_valid_r || !out_stall;
      end
    endcase
  end

  assign in_stall = in_stall_c;

  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_QUERY)) begin
      query_r <= wr_color;
    end
  end

  // issue into the distance pipeline
  assign entry_idx      = IDX_W'(step_r - STEP_W'(1));
  assign issue_ctl.init = issue_init;
  assign issue_ctl.live = issue_init ||
                          (shift_ring && head.eligible &&
                           (CMP_W'(entry_idx) < CMP_W'(entries_in_use_r)));
  assign issue_color    = issue_init ? color_t'('0) : head.color;

  npcs_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (issue_ctl),
    .in_idx   (entry_idx),
    .query    (query_r),
    .entry    (issue_color),
    .out_ctl  (d_ctl),
    .out_idx  (d_idx),
    .out_dist (d_dist)
  );

  // running minimum, first minimum wins
  always_ff @(posedge clk) begin
    if (d_ctl.live) begin
      if (d_ctl.init) begin
        best_r  <= d_dist;
        pixel_r <= black_pixel_r;
      end else if (d_dist < best_r) begin
        best_r  <= d_dist;
        pixel_r <= NPCS_PIXEL_W'(d_idx);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel_r <= pixel_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_pixel = out_pixel_r;

`ifndef NO_ASSERTIONS
  a_drained_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !d_ctl.live)
    else $error("distance pipeline not drained when result is taken");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of done state");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_command == CMD_QUERY)) |=> (state_r == ST_SCAN) && (step_r == '0))
    else $error("query request did not start a scan");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r <= STEP_LAST))
    else $error("scan step beyond palette");
`endif

endmodule

[rtl/core/npcs_cell.sv]
// ----------------------------------------------------------------------------
// npcs_cell
// one palette entry of the rotating ring, loaded by a write or from its neighbor
// ----------------------------------------------------------------------------
module npcs_cell import npcs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  logic   wr_en,
  input  color_t wr_color,
  input  logic   wr_eligible,
  input  cell_t  nb_in,
  output cell_t  q
);

  logic   elig_r;
  color_t color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elig_r <= 1'b0;
    end else if (wr_en) begin
      elig_r <= wr_eligible;
    end else if (shift) begin
      elig_r <= nb_in.eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_r <= wr_color;
    end else if (shift) begin
      color_r <= nb_in.color;
    end
  end

  assign q.eligible = elig_r;
  assign q.color    = color_r;

endmodule

[rtl/core/npcs_dist.sv]
// ----------------------------------------------------------------------------
// npcs_dist
// three-stage squared euclidean distance pipeline with a tag
// ----------------------------------------------------------------------------
module npcs_dist import npcs_pkg::*; #(
  parameter int IDX_W = $clog2(NPCS_PALETTE_ENTRIES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_t                   in_ctl,
  input  logic [IDX_W-1:0]       in_idx,
  input  color_t                 query,
  input  color_t                 entry,
  output ctl_t                   out_ctl,
  output logic [IDX_W-1:0]       out_idx,
  output logic [NPCS_DIST_W-1:0] out_dist
);

  ctl_t                   s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [IDX_W-1:0]       s1_idx_r, s2_idx_r, s3_idx_r;
  logic [NPCS_COMP_W-1:0] s1_dr_r, s1_dg_r, s1_db_r;
  logic [NPCS_SQ_W-1:0]   s2_sr_r, s2_sg_r, s2_sb_r;
  logic [NPCS_DIST_W-1:0] s3_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      s1_ctl_r <= in_ctl;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= in_idx;
    s1_dr_r   <= abs_diff(query.red, entry.red);
    s1_dg_r   <= abs_diff(query.green, entry.green);
    s1_db_r   <= abs_diff(query.blue, entry.blue);
    s2_idx_r  <= s1_idx_r;
    s2_sr_r   <= NPCS_SQ_W'(s1_dr_r) * NPCS_SQ_W'(s1_dr_r);
    s2_sg_r   <= NPCS_SQ_W'(s1_dg_r) * NPCS_SQ_W'(s1_dg_r);
    s2_sb_r   <= NPCS_SQ_W'(s1_db_r) * NPCS_SQ_W'(s1_db_r);
    s3_idx_r  <= s2_idx_r;
    s3_dist_r <= NPCS_DIST_W'(s2_sr_r) + NPCS_DIST_W'(s2_sg_r) + NPCS_DIST_W'(s2_sb_r);
  end

  assign out_ctl  = s3_ctl_r;
  assign out_idx  = s3_idx_r;
  assign out_dist = s3_dist_r;

endmodule

[tb/sv/tb_nearest_palette_color_search_top.sv]
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search_top
// self-checking bench: palette writes and nearest color queries are driven
// under random idling and back pressure, every query is predicted by an
// in-bench palette model and each best_pixel result is compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_palette_color_search_top;
  import npcs_pkg::*;

  localparam int PALETTE      = NPCS_PALETTE_ENTRIES;
  localparam int DRAIN_CYCLES = PALETTE + 20;
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_LIMIT   = 20000;

  localparam logic [NPCS_CFG_IDX_W-1:0] CFG_UNUSED_2 = NPCS_CFG_IDX_W'(2);
  localparam logic [NPCS_CFG_IDX_W-1:0] CFG_UNUSED_3 = NPCS_CFG_IDX_W'(3);

  typedef struct {
    logic                        cmd;
    logic [NPCS_ENTRY_IDX_W-1:0] idx;
    color_t                      col;
    logic                        el;
  } palette_req_t;

  typedef struct {
    logic [NPCS_CFG_IDX_W-1:0]  idx;
    logic [NPCS_CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_command = CMD_WRITE;
  logic [NPCS_ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic [NPCS_COMP_W-1:0]      in_red = '0;
  logic [NPCS_COMP_W-1:0]      in_green = '0;
  logic [NPCS_COMP_W-1:0]      in_blue = '0;
  logic                        in_eligible = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [NPCS_PIXEL_W-1:0]     out_best_pixel;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [NPCS_CFG_IDX_W-1:0]   cfg_index = '0;
  logic [NPCS_CFG_DATA_W-1:0]  cfg_data = '0;

  nearest_palette_color_search_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_eligible    (in_eligible),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_pixel (out_best_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // palette model
  logic [NPCS_COMP_W-1:0]  shade_red   [PALETTE];
  logic [NPCS_COMP_W-1:0]  shade_green [PALETTE];
  logic [NPCS_COMP_W-1:0]  shade_blue  [PALETTE];
  logic                    shade_el    [PALETTE];
  logic [NPCS_LIMIT_W-1:0] model_limit = NPCS_LIMIT_RST;
  logic [NPCS_PIXEL_W-1:0] model_black = NPCS_BLACK_RST;

  palette_req_t            req_q[$];
  reg_write_t              reg_q[$];
  logic [NPCS_PIXEL_W-1:0] best_pixel_q[$];
  palette_req_t            cur_req;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int errors = 0;

  // stimulus bookkeeping
  color_t gen_col[PALETTE];
  int     written_idx[$];
  int     gen_limit = PALETTE;

  initial begin
    for (int i = 0; i < PALETTE; i++) begin
      shade_red[i] = '0;
      shade_green[i] = '0;
      shade_blue[i] = '0;
      shade_el[i] = 1'b0;
    end
  end

  function automatic logic [NPCS_DIST_W-1:0] sq_dist(input logic [NPCS_COMP_W-1:0] a,
                                                      input logic [NPCS_COMP_W-1:0] b);
    logic [NPCS_DIST_W-1:0] d;
    d = (a >= b) ? NPCS_DIST_W'(a - b) : NPCS_DIST_W'(b - a);
    return d * d;
  endfunction

  function automatic logic [NPCS_PIXEL_W-1:0] nearest_entry(input color_t c);
    logic [NPCS_DIST_W-1:0]  best;
    logic [NPCS_DIST_W-1:0]  d;
    logic [NPCS_PIXEL_W-1:0] pixel;
    int                      lim;
    best = sq_dist(c.red, '0) + sq_dist(c.green, '0) + sq_dist(c.blue, '0);
    pixel = model_black;
    lim = (model_limit > PALETTE) ? PALETTE : int'(model_limit);
    for (int i = 0; i < lim; i++) begin
      if (shade_el[i]) begin
        d = sq_dist(c.red, shade_red[i]) + sq_dist(c.green, shade_green[i])
            + sq_dist(c.blue, shade_blue[i]);
        if (d < best) begin
          best = d;
          pixel = NPCS_PIXEL_W'(i);
        end
      end
    end
    return pixel;
  endfunction

  task automatic apply_request(input palette_req_t q);
    if (q.cmd == CMD_WRITE) begin
      if (int'(q.idx) < PALETTE) begin
        shade_red[q.idx] = q.col.red;
        shade_green[q.idx] = q.col.green;
        shade_blue[q.idx] = q.col.blue;
        shade_el[q.idx] = q.el;
      end
    end else begin
      best_pixel_q.push_back(nearest_entry(q.col));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(cur_req);
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          cur_req = req_q.pop_front();
          in_command <= cur_req.cmd;
          in_entry_index <= cur_req.idx;
          in_red <= cur_req.col.red;
          in_green <= cur_req.col.green;
          in_blue <= cur_req.col.blue;
          in_eligible <= cur_req.el;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    reg_write_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENTRIES_IN_USE) model_limit = cfg_data;
        else if (cfg_index == CFG_BLACK_PIXEL) model_black = cfg_data[NPCS_PIXEL_W-1:0];
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_q.size() != 0) begin
          w = reg_q.pop_front();
          cfg_index <= w.idx;
          cfg_data <= w.data;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [NPCS_PIXEL_W-1:0] exp_pixel;
    if (out_valid && !out_stall && rst_n) begin
      if (best_pixel_q.size() == 0) begin
        if (errors < 10) $display("unexpected result: best_pixel %0d", out_best_pixel);
        errors++;
      end else begin
        exp_pixel = best_pixel_q.pop_front();
        if (out_best_pixel !== exp_pixel) begin
          if (errors < 10)
            $display("best_pixel mismatch: expected %0d, got %0d", exp_pixel, out_best_pixel);
          errors++;
        end
      end
    end
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [NPCS_COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return NPCS_COMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [NPCS_COMP_W-1:0] nudge(input logic [NPCS_COMP_W-1:0] c);
    int k;
    int d;
    int v;
    k = $urandom_range(0, 12);
    d = $urandom_range(0, 1 << k);
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return NPCS_COMP_W'(v);
  endfunction

  function automatic color_t rand_color();
    color_t c;
    c.red = rand_comp();
    c.green = rand_comp();
    c.blue = rand_comp();
    return c;
  endfunction

  function automatic color_t near_color(input color_t c);
    color_t n;
    n.red = nudge(c.red);
    n.green = nudge(c.green);
    n.blue = nudge(c.blue);
    return n;
  endfunction

  function automatic color_t some_entry();
    return gen_col[written_idx[$urandom_range(0, written_idx.size() - 1)]];
  endfunction

  task automatic add_req(input logic cmd, input int idx, input int r, input int g, input int b,
                         input logic el);
    palette_req_t q;
    q.cmd = cmd;
    q.idx = NPCS_ENTRY_IDX_W'(idx);
    q.col.red = NPCS_COMP_W'(r);
    q.col.green = NPCS_COMP_W'(g);
    q.col.blue = NPCS_COMP_W'(b);
    q.el = el;
    if (cmd == CMD_WRITE) begin
      gen_col[idx] = q.col;
      written_idx.push_back(idx);
    end
    req_q.push_back(q);
  endtask

  task automatic add_random(input int n);
    palette_req_t q;
    int           v;
    for (int i = 0; i < n; i++) begin
      q.idx = NPCS_ENTRY_IDX_W'($urandom);
      q.el = 1'($urandom_range(0, 1));
      q.col = rand_color();
      if ($urandom_range(0, 99) < 55) begin
        q.cmd = CMD_WRITE;
        q.el = ($urandom_range(0, 9) < 8);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: q.idx = NPCS_ENTRY_IDX_W'($urandom_range(0, 31));
          5, 6, 7: begin
            v = gen_limit + $urandom_range(0, 8) - 4;
            if (v < 0) v = 0;
            if (v > PALETTE - 1) v = PALETTE - 1;
            q.idx = NPCS_ENTRY_IDX_W'(v);
          end
          default: q.idx = NPCS_ENTRY_IDX_W'($urandom);
        endcase
        if (written_idx.size() != 0) begin
          case ($urandom_range(0, 5))
            0:       q.col = some_entry();
            1, 2:    q.col = near_color(some_entry());
            default: q.col = rand_color();
          endcase
        end
        gen_col[q.idx] = q.col;
        written_idx.push_back(int'(q.idx));
      end else begin
        q.cmd = CMD_QUERY;
        if (written_idx.size() != 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: q.col = near_color(some_entry());
            5, 6:          q.col = some_entry();
            9: begin
              q.col.red = NPCS_COMP_W'($urandom_range(0, 300));
              q.col.green = NPCS_COMP_W'($urandom_range(0, 300));
              q.col.blue = NPCS_COMP_W'($urandom_range(0, 300));
            end
            default: ;
          endcase
        end
      end
      req_q.push_back(q);
    end
  endtask

  task automatic set_reg(input logic [NPCS_CFG_IDX_W-1:0] idx, input int data);
    reg_write_t w;
    w.idx = idx;
    w.data = NPCS_CFG_DATA_W'(data);
    if (idx == CFG_ENTRIES_IN_USE) gen_limit = (data > PALETTE - 1) ? PALETTE - 1 : data;
    reg_q.push_back(w);
    do @(negedge clk); while (reg_q.size() != 0 || cfg_valid);
  endtask

  // sender pauses here until every query has its result
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || best_pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic hold_receiver(input int after);
    int target;
    target = (req_q.size() > after) ? req_q.size() - after : 0;
    while (req_q.size() > target) @(negedge clk);
    hold_reqs++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle_pct = 15;
    rcv_idle_pct = 70;
    set_reg(CFG_BLACK_PIXEL, 8'h5a);
    // empty palette, extremes
    add_req(CMD_QUERY, 0, 0, 0, 0, 1'b0);
    add_req(CMD_QUERY, 255, 65535, 65535, 65535, 1'b1);
    add_req(CMD_WRITE, 0, 65535, 65535, 65535, 1'b1);
    add_req(CMD_QUERY, 0, 65535, 65535, 65535, 1'b0);
    add_req(CMD_WRITE, 255, 0, 0, 1, 1'b1);
    add_req(CMD_QUERY, 0, 0, 0, 2, 1'b0);
    // tie with the distance to black keeps the fallback
    add_req(CMD_WRITE, 10, 200, 0, 0, 1'b1);
    add_req(CMD_QUERY, 0, 100, 0, 0, 1'b0);
    add_req(CMD_WRITE, 11, 199, 0, 0, 1'b1);
    add_req(CMD_QUERY, 0, 100, 0, 0, 1'b0);
    // duplicate entry, first minimum wins
    add_req(CMD_WRITE, 12, 199, 0, 0, 1'b1);
    add_req(CMD_QUERY, 0, 100, 0, 0, 1'b0);
    // clearing the eligible bit
    add_req(CMD_WRITE, 11, 199, 0, 0, 1'b0);
    add_req(CMD_QUERY, 0, 100, 0, 0, 1'b0);
    add_req(CMD_WRITE, 1, 0, 65535, 0, 1'b0);
    add_req(CMD_QUERY, 0, 0, 65535, 0, 1'b0);
    add_req(CMD_QUERY, 0, 65535, 0, 65535, 1'b1);
    add_req(CMD_QUERY, 0, 1, 1, 1, 1'b0);
    wait_drained();

    set_reg(CFG_ENTRIES_IN_USE, 1);
    add_random(200);
    wait_drained();
    set_reg(CFG_ENTRIES_IN_USE, 0);
    set_reg(CFG_BLACK_PIXEL, 255);
    add_random(100);
    wait_drained();
    set_reg(CFG_ENTRIES_IN_USE, 511);
    set_reg(CFG_UNUSED_2, $urandom_range(0, 511));
    set_reg(CFG_UNUSED_3, $urandom_range(0, 511));
    set_reg(CFG_BLACK_PIXEL, 256 + $urandom_range(0, 255));
    add_random(350);
    wait_drained();

    snd_idle_pct = 70;
    rcv_idle_pct = 15;
    set_reg(CFG_ENTRIES_IN_USE, 257);
    set_reg(CFG_BLACK_PIXEL, 0);
    add_random(350);
    wait_drained();
    set_reg(CFG_ENTRIES_IN_USE, $urandom_range(2, 255));
    set_reg(CFG_BLACK_PIXEL, $urandom_range(0, 511));
    add_random(350);
    hold_receiver(30);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_reg(CFG_ENTRIES_IN_USE, 256);
    add_random(350);
    hold_receiver(40);
    wait_drained();
    set_reg(CFG_ENTRIES_IN_USE, $urandom_range(2, 255));
    set_reg(CFG_BLACK_PIXEL, $urandom_range(0, 255));
    add_random(130);
    wait_drained();

    errors += best_pixel_q.size();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
